### rtl/core/vcsd_pkg.sv
package vcsd_pkg;

    // configuration register indexes (byte address is 4 * index)
    localparam int unsigned NUM_REGS   = 5;
    localparam int unsigned PADDR_W    = 5;
    localparam int unsigned REG_IDX_W  = 3;
    localparam logic [REG_IDX_W-1:0] REG_ODO_ID    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_VIN_ID    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MODE_ID   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BUTTON_ID = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_IGN_ID    = 3'd4;

    localparam int unsigned ID_W = 11;
    localparam logic [ID_W-1:0] ODO_ID_RST    = 11'h65D;
    localparam logic [ID_W-1:0] VIN_ID_RST    = 11'h65F;
    localparam logic [ID_W-1:0] MODE_ID_RST   = 11'h661;
    localparam logic [ID_W-1:0] BUTTON_ID_RST = 11'h461;
    localparam logic [ID_W-1:0] IGN_ID_RST    = 11'h2C3;

    // vehicle number part selectors (byte 0)
    localparam logic [7:0] VIN_SEL_PART0 = 8'h00;
    localparam logic [7:0] VIN_SEL_PART1 = 8'h01;
    localparam logic [7:0] VIN_SEL_PART2 = 8'h02;
    localparam int unsigned VIN_LEN      = 17;
    localparam int unsigned VIN_PART2_AT = 10;

    // source mode frame bytes
    localparam logic [7:0] MODE_B1      = 8'h01;
    localparam logic [7:0] MODE_B2      = 8'h12;
    localparam logic [7:0] MODE_GRP_A   = 8'hA3;
    localparam logic [7:0] MODE_GRP_B   = 8'h83;
    localparam logic [7:0] MODE_C_MP3   = 8'hA4;
    localparam logic [7:0] MODE_C_CD    = 8'hA5;
    localparam logic [7:0] MODE_C_RADIO = 8'hA0;
    localparam logic [7:0] MODE_C_AUX   = 8'hA4;
    localparam logic [7:0] MODE_C_SAT   = 8'h2F;
    localparam logic [7:0] MODE_C_TV    = 8'h37;

    localparam logic [2:0] MODE_UNKNOWN = 3'd0;
    localparam logic [2:0] MODE_MP3     = 3'd1;
    localparam logic [2:0] MODE_CD      = 3'd2;
    localparam logic [2:0] MODE_RADIO   = 3'd3;
    localparam logic [2:0] MODE_AUX     = 3'd4;
    localparam logic [2:0] MODE_SAT     = 3'd5;
    localparam logic [2:0] MODE_TV      = 3'd6;

    // button frame bytes
    localparam logic [7:0] BTN_B0      = 8'h37;
    localparam logic [7:0] BTN_B1      = 8'h30;
    localparam logic [7:0] BTN_B2      = 8'h01;
    localparam logic [7:0] BTN_C_BACK  = 8'h02;
    localparam logic [7:0] BTN_C_FWD   = 8'h01;

    localparam logic [1:0] KEY_NONE = 2'd0;
    localparam logic [1:0] KEY_BACK = 2'd1;
    localparam logic [1:0] KEY_FWD  = 2'd2;

    // ignition frame codes (byte 0)
    localparam logic [7:0] IGN_C_NO_KEY   = 8'h10;
    localparam logic [7:0] IGN_C_KEY_IN   = 8'h11;
    localparam logic [7:0] IGN_C_UNLOCKED = 8'h01;
    localparam logic [7:0] IGN_C_DISPLAY  = 8'h05;
    localparam logic [7:0] IGN_C_IGNITION = 8'h07;
    localparam logic [7:0] IGN_C_STARTER  = 8'h0B;

    localparam logic [2:0] IGN_NO_KEY   = 3'd1;
    localparam logic [2:0] IGN_KEY_IN   = 3'd2;
    localparam logic [2:0] IGN_UNLOCKED = 3'd3;
    localparam logic [2:0] IGN_DISPLAY  = 3'd4;
    localparam logic [2:0] IGN_IGNITION = 3'd5;
    localparam logic [2:0] IGN_STARTER  = 3'd6;

    localparam logic [3:0] ODO_NIBBLE_MASK = 4'hF;

    // command queue
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        VIN_NONE,
        VIN_PART0,
        VIN_PART1,
        VIN_PART2
    } vin_part_t;

    typedef struct packed {
        logic [ID_W-1:0] odo;
        logic [ID_W-1:0] vin;
        logic [ID_W-1:0] mode;
        logic [ID_W-1:0] button;
        logic [ID_W-1:0] ign;
    } cfg_ids_t;

    // decoded frame, bytes 1..7 kept for the vehicle number (byte 1 on top)
    typedef struct packed {
        logic        odo_en;
        logic [19:0] odo_val;
        vin_part_t   vin_part;
        logic [55:0] vin_bytes;
        logic        mode_en;
        logic [2:0]  mode_val;
        logic [1:0]  key;
        logic        ign_en;
        logic [2:0]  ign_val;
    } cmd_t;

endpackage

### rtl/core/vcsd_front.sv
module vcsd_front
    import vcsd_pkg::*;
(
    input  cfg_ids_t        ids,
    input  logic [ID_W-1:0] frame_id,
    input  logic [7:0]      byte_0,
    input  logic [7:0]      byte_1,
    input  logic [7:0]      byte_2,
    input  logic [7:0]      byte_3,
    input  logic [7:0]      byte_4,
    input  logic [7:0]      byte_5,
    input  logic [7:0]      byte_6,
    input  logic [7:0]      byte_7,
    output cmd_t            cmd
);

    always_comb
    begin
        cmd = '0;

        // odometer: low nibble of byte 3, then byte 2, then byte 1
        cmd.odo_en  = (frame_id == ids.odo);
        cmd.odo_val = {byte_3[3:0] & ODO_NIBBLE_MASK, byte_2, byte_1};

        cmd.vin_bytes = {byte_1, byte_2, byte_3, byte_4, byte_5, byte_6, byte_7};
        cmd.vin_part  = VIN_NONE;
        if (frame_id == ids.vin)
        begin
            unique case (byte_0)
                VIN_SEL_PART0: cmd.vin_part = VIN_PART0;
                VIN_SEL_PART1: cmd.vin_part = VIN_PART1;
                VIN_SEL_PART2: cmd.vin_part = VIN_PART2;
                default:       cmd.vin_part = VIN_NONE;
            endcase
        end

        cmd.mode_en  = 1'b0;
        cmd.mode_val = MODE_UNKNOWN;
        if (frame_id == ids.mode && byte_1 == MODE_B1 && byte_2 == MODE_B2)
        begin
            priority if (byte_0 == MODE_GRP_A)
            begin
                priority if (byte_3 == MODE_C_MP3)
                begin
                    cmd.mode_en  = 1'b1;
                    cmd.mode_val = MODE_MP3;
                end
                else if (byte_3 == MODE_C_CD)
                begin
                    cmd.mode_en  = 1'b1;
                    cmd.mode_val = MODE_CD;
                end
                else
                begin
                    cmd.mode_en = 1'b0;
                end
            end
            else if (byte_0 == MODE_GRP_B)
            begin
                priority if (byte_3 == MODE_C_RADIO)
                begin
                    cmd.mode_en  = 1'b1;
                    cmd.mode_val = MODE_RADIO;
                end
                else if (byte_3 == MODE_C_AUX)
                begin
                    cmd.mode_en  = 1'b1;
                    cmd.mode_val = MODE_AUX;
                end
                else if (byte_3 == MODE_C_SAT)
                begin
                    cmd.mode_en  = 1'b1;
                    cmd.mode_val = MODE_SAT;
                end
                else if (byte_3 == MODE_C_TV)
                begin
                    cmd.mode_en  = 1'b1;
                    cmd.mode_val = MODE_TV;
                end
                else
                begin
                    cmd.mode_en = 1'b0;
                end
            end
            else
            begin
                cmd.mode_en = 1'b0;
            end
        end

        cmd.key = KEY_NONE;
        if (frame_id == ids.button && byte_0 == BTN_B0 && byte_1 == BTN_B1
            && byte_2 == BTN_B2)
        begin
            priority if (byte_3 == BTN_C_BACK)
                cmd.key = KEY_BACK;
            else if (byte_3 == BTN_C_FWD)
                cmd.key = KEY_FWD;
            else
                cmd.key = KEY_NONE;
        end

        cmd.ign_en  = 1'b0;
        cmd.ign_val = IGN_NO_KEY;
        if (frame_id == ids.ign)
        begin
            cmd.ign_en = 1'b1;
            unique case (byte_0)
                IGN_C_NO_KEY:   cmd.ign_val = IGN_NO_KEY;
                IGN_C_KEY_IN:   cmd.ign_val = IGN_KEY_IN;
                IGN_C_UNLOCKED: cmd.ign_val = IGN_UNLOCKED;
                IGN_C_DISPLAY:  cmd.ign_val = IGN_DISPLAY;
                IGN_C_IGNITION: cmd.ign_val = IGN_IGNITION;
                IGN_C_STARTER:  cmd.ign_val = IGN_STARTER;
                default:        cmd.ign_en  = 1'b0;
            endcase
        end
    end

endmodule

### rtl/core/vcsd_queue.sv
module vcsd_queue
    import vcsd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t pop_cmd
);

    cmd_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;

    localparam logic [Q_PTR_W-1:0] PTR_LAST = Q_PTR_W'(Q_DEPTH - 1);
    localparam logic [Q_CNT_W-1:0] CNT_FULL = Q_CNT_W'(Q_DEPTH);

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

### rtl/core/vcsd_back.sv
module vcsd_back
    import vcsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_avail,
    input  cmd_t        cmd,
    output logic        cmd_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [19:0] odometer,
    output logic [2:0]  radio_mode,
    output logic [2:0]  ignition_state,
    output logic        ignition_on,
    output logic [1:0]  key_event,
    output logic        vin_ready,
    output logic [63:0] vin_first,
    output logic [63:0] vin_second,
    output logic [7:0]  vin_last
);

    logic [19:0] odometer_reg;
    logic [19:0] odometer_next;
    logic [2:0]  mode_reg;
    logic [2:0]  mode_next;
    logic [2:0]  ignition_reg;
    logic [2:0]  ignition_next;
    logic        vin_valid_reg;
    logic        vin_valid_next;
    logic [7:0]  vin_work_reg [VIN_LEN];
    logic [7:0]  vin_done_reg [VIN_LEN];
    logic [7:0]  vin_done_next [VIN_LEN];
    logic [7:0]  new_byte [7];

    logic        out_valid_reg;
    logic [19:0] res_odo_reg;
    logic [2:0]  res_mode_reg;
    logic [2:0]  res_ign_reg;
    logic        res_ign_on_reg;
    logic [1:0]  res_key_reg;
    logic        res_vin_ready_reg;
    logic [63:0] res_first_reg;
    logic [63:0] res_second_reg;
    logic [7:0]  res_last_reg;

    // output register free or being drained this cycle
    assign cmd_pop = cmd_avail && (!out_valid_reg || out_ready);

    always_comb
    begin
        for (int i = 0; i < 7; i++)
            new_byte[i] = cmd.vin_bytes[55 - 8*i -: 8];
    end

    always_comb
    begin
        odometer_next  = cmd.odo_en  ? cmd.odo_val  : odometer_reg;
        mode_next      = cmd.mode_en ? cmd.mode_val : mode_reg;
        ignition_next  = cmd.ign_en  ? cmd.ign_val  : ignition_reg;
        vin_valid_next = vin_valid_reg || (cmd.vin_part == VIN_PART2);
        for (int i = 0; i < VIN_LEN; i++)
        begin
            if (cmd.vin_part != VIN_PART2)
                vin_done_next[i] = vin_done_reg[i];
            else if (i < VIN_PART2_AT)
                vin_done_next[i] = vin_work_reg[i];
            else
                vin_done_next[i] = new_byte[i - VIN_PART2_AT];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            odometer_reg  <= '0;
            mode_reg      <= MODE_UNKNOWN;
            ignition_reg  <= IGN_NO_KEY;
            vin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < VIN_LEN; i++)
                vin_done_reg[i] <= '0;
        end
        else
        begin
            if (cmd_pop)
            begin
                odometer_reg  <= odometer_next;
                mode_reg      <= mode_next;
                ignition_reg  <= ignition_next;
                vin_valid_reg <= vin_valid_next;
                for (int i = 0; i < VIN_LEN; i++)
                    vin_done_reg[i] <= vin_done_next[i];
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // work slots: no reset; a part 2 frame copies slots 0..9 even if parts 0 and 1 never wrote them
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            unique case (cmd.vin_part)
                VIN_PART0:
                begin
                    for (int i = 0; i < 3; i++)
                        vin_work_reg[i] <= new_byte[4 + i];
                end
                VIN_PART1:
                begin
                    for (int i = 0; i < 7; i++)
                        vin_work_reg[3 + i] <= new_byte[i];
                end
                VIN_PART2:
                begin
                    for (int i = 0; i < 7; i++)
                        vin_work_reg[VIN_PART2_AT + i] <= new_byte[i];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            res_odo_reg       <= odometer_next;
            res_mode_reg      <= mode_next;
            res_ign_reg       <= ignition_next;
            res_ign_on_reg    <= (ignition_next >= IGN_DISPLAY);
            res_key_reg       <= cmd.key;
            res_vin_ready_reg <= vin_valid_next;
            for (int i = 0; i < 8; i++)
            begin
                res_first_reg[63 - 8*i -: 8]  <= vin_done_next[i];
                res_second_reg[63 - 8*i -: 8] <= vin_done_next[8 + i];
            end
            res_last_reg <= vin_done_next[VIN_LEN - 1];
        end
    end

    assign out_valid      = out_valid_reg;
    assign odometer       = res_odo_reg;
    assign radio_mode     = res_mode_reg;
    assign ignition_state = res_ign_reg;
    assign ignition_on    = res_ign_on_reg;
    assign key_event      = res_key_reg;
    assign vin_ready      = res_vin_ready_reg;
    assign vin_first      = res_first_reg;
    assign vin_second     = res_second_reg;
    assign vin_last       = res_last_reg;

`ifndef SYNTHESIS
    a_vin_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(vin_valid_reg))
        else $error("published vehicle number flag dropped");

    a_ign_range: assert property (@(posedge clk) disable iff (!rst_n)
        ignition_reg >= IGN_NO_KEY && ignition_reg <= IGN_STARTER)
        else $error("ignition state out of range");

    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg <= MODE_TV)
        else $error("radio mode out of range");

    a_ign_on_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (res_ign_on_reg == (res_ign_reg >= IGN_DISPLAY)))
        else $error("ignition_on disagrees with ignition state");

    a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> out_valid_reg && res_odo_reg == odometer_reg)
        else $error("result register not loaded with decoded state");
`endif

endmodule

### rtl/core/vehicle_can_status_decoder_core.sv
// channel  | handshake                  | payload
// ---------+----------------------------+--------------------------------------
// in       | in_valid / in_ready        | frame_id, byte_0 .. byte_7
// out      | out_valid / out_ready      | odometer, radio_mode, ignition_state,
//          |                            | ignition_on, key_event, vin_ready,
//          |                            | vin_first, vin_second, vin_last
// cfg      | psel/penable/pwrite/pready | paddr, pwdata, prdata (5 id registers)
//
// one frame per cycle while out_ready is high; a result is registered in the queue, then in the output register
// reset (rst_n low, asynchronous) loads the default identifiers and clears state
// the front stalls only when the two-entry command queue is full
// the back stalls only when the output register holds a result not yet taken
module vehicle_can_status_decoder_core
    import vcsd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    // apb configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,

    // frame input
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [ID_W-1:0]    frame_id,
    input  logic [7:0]         byte_0,
    input  logic [7:0]         byte_1,
    input  logic [7:0]         byte_2,
    input  logic [7:0]         byte_3,
    input  logic [7:0]         byte_4,
    input  logic [7:0]         byte_5,
    input  logic [7:0]         byte_6,
    input  logic [7:0]         byte_7,

    // result output
    output logic               out_valid,
    input  logic               out_ready,
    output logic [19:0]        odometer,
    output logic [2:0]         radio_mode,
    output logic [2:0]         ignition_state,
    output logic               ignition_on,
    output logic [1:0]         key_event,
    output logic               vin_ready,
    output logic [63:0]        vin_first,
    output logic [63:0]        vin_second,
    output logic [7:0]         vin_last
);

    cfg_ids_t              ids_reg;
    cfg_ids_t              ids_next;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic                  cfg_wr;
    cmd_t                  front_cmd;
    cmd_t                  back_cmd;
    logic                  q_full;
    logic                  q_not_empty;
    logic                  q_pop;
    logic                  push;

    // ---------------- configuration registers ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    // a write lands in the access phase; indexes past the list are dropped
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        ids_next = ids_reg;
        if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_ODO_ID:    ids_next.odo    = pwdata[ID_W-1:0];
                REG_VIN_ID:    ids_next.vin    = pwdata[ID_W-1:0];
                REG_MODE_ID:   ids_next.mode   = pwdata[ID_W-1:0];
                REG_BUTTON_ID: ids_next.button = pwdata[ID_W-1:0];
                REG_IGN_ID:    ids_next.ign    = pwdata[ID_W-1:0];
                default:       ids_next        = ids_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_ODO_ID:    prdata = {{(32-ID_W){1'b0}}, ids_reg.odo};
            REG_VIN_ID:    prdata = {{(32-ID_W){1'b0}}, ids_reg.vin};
            REG_MODE_ID:   prdata = {{(32-ID_W){1'b0}}, ids_reg.mode};
            REG_BUTTON_ID: prdata = {{(32-ID_W){1'b0}}, ids_reg.button};
            REG_IGN_ID:    prdata = {{(32-ID_W){1'b0}}, ids_reg.ign};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ids_reg.odo    <= ODO_ID_RST;
            ids_reg.vin    <= VIN_ID_RST;
            ids_reg.mode   <= MODE_ID_RST;
            ids_reg.button <= BUTTON_ID_RST;
            ids_reg.ign    <= IGN_ID_RST;
        end
        else
        begin
            ids_reg <= ids_next;
        end
    end

    // ---------------- front: classify the frame ----------------
    vcsd_front u_front (
        .ids      (ids_reg),
        .frame_id (frame_id),
        .byte_0   (byte_0),
        .byte_1   (byte_1),
        .byte_2   (byte_2),
        .byte_3   (byte_3),
        .byte_4   (byte_4),
        .byte_5   (byte_5),
        .byte_6   (byte_6),
        .byte_7   (byte_7),
        .cmd      (front_cmd)
    );

    // a transaction is taken whenever the queue has room
    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    // ---------------- decoupling queue ----------------
    vcsd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_cmd   (back_cmd)
    );

    // ---------------- back: apply to state and register result ----------------
    vcsd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_avail      (q_not_empty),
        .cmd            (back_cmd),
        .cmd_pop        (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .odometer       (odometer),
        .radio_mode     (radio_mode),
        .ignition_state (ignition_state),
        .ignition_on    (ignition_on),
        .key_event      (key_event),
        .vin_ready      (vin_ready),
        .vin_first      (vin_first),
        .vin_second     (vin_second),
        .vin_last       (vin_last)
    );

endmodule
